FILE: rtl/vlmr_pkg.sv
// Shared types, field widths and codes for the variable-length message ring.
package vlmr_pkg;

  localparam int unsigned KIND_W       = 3;
  localparam int unsigned PAYLOAD_W    = 13;
  localparam int unsigned OFFSET_W     = 12;
  localparam int unsigned BYTE_W       = 8;
  localparam int unsigned QLEN_W       = 13;
  localparam int unsigned RES_W        = 12;
  localparam int unsigned S_TDATA_W    = 40;
  localparam int unsigned S_TUSER_W    = 3;
  localparam int unsigned M_TDATA_W    = 48;
  // The header's length field spans eight bytes; only the low two matter
  // against a ring of at most 8191 bytes, the rest only need a nonzero flag.
  localparam int unsigned HDR_LEN_BYTES = 8;
  localparam int unsigned HDR_IDX_W     = 3;
  localparam int unsigned HDR_KEEP_W    = 16;

  localparam logic [QLEN_W-1:0] QLEN_RESET = 13'd4096;

  typedef enum logic [KIND_W-1:0] {
    KIND_ADD_BEGIN    = 3'd0,
    KIND_PUT_BYTE     = 3'd1,
    KIND_ADD_COMPLETE = 3'd2,
    KIND_GET_BEGIN    = 3'd3,
    KIND_GET_BYTE     = 3'd4,
    KIND_GET_COMPLETE = 3'd5
  } kind_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_EXEC,
    ST_MOD,
    ST_APPLY,
    ST_HDR,
    ST_HWAIT,
    ST_FIN
  } state_e;

  typedef struct packed {
    logic item_load;
    logic mod_start;
    logic ram_we;
    logic ram_re;
    logic wp_load;
    logic rp_load;
    logic hdr_start;
    logic hdr_rd;
    logic out_load;
  } cmd_t;

  typedef struct packed {
    kind_e kind;
    logic  wp_ok;
    logic  ptrs_ok;
    logic  empty;
    logic  len_small;
    logic  gc_ok;
    logic  mod_done;
    logic  hdr_last;
    logic  out_free;
  } sts_t;

endpackage

FILE: rtl/vlmr_ram.sv
// Generic simple dual-port RAM with registered read data.
module vlmr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/vlmr_ctrl.sv
// Controller state machine: sequences one operation through the datapath.
module vlmr_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           s_valid_i,
  input  logic           cfg_valid_i,
  input  vlmr_pkg::sts_t sts_i,
  output vlmr_pkg::cmd_t cmd_o,
  output logic           s_ready_o,
  output logic           cfg_ready_o
);

  vlmr_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= vlmr_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d     = state_q;
    cmd_o       = '0;
    s_ready_o   = 1'b0;
    cfg_ready_o = 1'b0;
    case (state_q)
      vlmr_pkg::ST_IDLE: begin
        // configuration writes win over a new beat
        cfg_ready_o = 1'b1;
        s_ready_o   = !cfg_valid_i;
        if (s_valid_i && !cfg_valid_i) begin
          cmd_o.item_load = 1'b1;
          state_d         = vlmr_pkg::ST_EXEC;
        end
      end
      vlmr_pkg::ST_EXEC: begin
        state_d = vlmr_pkg::ST_FIN;
        case (sts_i.kind)
          vlmr_pkg::KIND_PUT_BYTE, vlmr_pkg::KIND_GET_BYTE: begin
            cmd_o.mod_start = 1'b1;
            state_d         = vlmr_pkg::ST_MOD;
          end
          vlmr_pkg::KIND_ADD_COMPLETE: begin
            if (sts_i.wp_ok) begin
              cmd_o.mod_start = 1'b1;
              state_d         = vlmr_pkg::ST_MOD;
            end
          end
          vlmr_pkg::KIND_GET_COMPLETE: begin
            if (sts_i.gc_ok) begin
              cmd_o.mod_start = 1'b1;
              state_d         = vlmr_pkg::ST_MOD;
            end
          end
          vlmr_pkg::KIND_GET_BEGIN: begin
            if (sts_i.ptrs_ok && !sts_i.empty && !sts_i.len_small) begin
              cmd_o.hdr_start = 1'b1;
              state_d         = vlmr_pkg::ST_HDR;
            end
          end
          default: begin
            state_d = vlmr_pkg::ST_FIN;
          end
        endcase
      end
      vlmr_pkg::ST_MOD: begin
        if (sts_i.mod_done) begin
          state_d = vlmr_pkg::ST_APPLY;
        end
      end
      vlmr_pkg::ST_APPLY: begin
        state_d = vlmr_pkg::ST_FIN;
        case (sts_i.kind)
          vlmr_pkg::KIND_PUT_BYTE:     cmd_o.ram_we  = 1'b1;
          vlmr_pkg::KIND_ADD_COMPLETE: cmd_o.wp_load = 1'b1;
          vlmr_pkg::KIND_GET_BYTE:     cmd_o.ram_re  = 1'b1;
          vlmr_pkg::KIND_GET_COMPLETE: cmd_o.rp_load = 1'b1;
          default: begin
            state_d = vlmr_pkg::ST_FIN;
          end
        endcase
      end
      vlmr_pkg::ST_HDR: begin
        cmd_o.hdr_rd = 1'b1;
        if (sts_i.hdr_last) begin
          state_d = vlmr_pkg::ST_HWAIT;
        end
      end
      vlmr_pkg::ST_HWAIT: begin
        // last header byte lands this cycle
        state_d = vlmr_pkg::ST_FIN;
      end
      vlmr_pkg::ST_FIN: begin
        if (sts_i.out_free) begin
          cmd_o.out_load = 1'b1;
          state_d        = vlmr_pkg::ST_IDLE;
        end
      end
      default: begin
        state_d = vlmr_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

FILE: rtl/vlmr_dp.sv
// Datapath: pointers, ring store, modulo unit, header assembly and result register.
module vlmr_dp #(
  parameter int unsigned QUEUE_BYTES  = 4096,
  parameter int unsigned HEADER_BYTES = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  vlmr_pkg::cmd_t                 cmd_i,
  output vlmr_pkg::sts_t                 sts_o,
  input  logic                           cfg_we_i,
  input  logic [vlmr_pkg::QLEN_W-1:0]    cfg_data_i,
  input  logic [vlmr_pkg::S_TDATA_W-1:0] s_tdata_i,
  input  logic [vlmr_pkg::S_TUSER_W-1:0] s_tuser_i,
  input  logic                           m_tready_i,
  output logic                           m_tvalid_o,
  output logic [vlmr_pkg::M_TDATA_W-1:0] m_tdata_o
);

  localparam int unsigned AW   = $clog2(QUEUE_BYTES);
  localparam int unsigned LW   = $clog2(QUEUE_BYTES + 1);
  localparam int unsigned CW   = (LW > vlmr_pkg::QLEN_W) ? LW : vlmr_pkg::QLEN_W;
  localparam int unsigned MSGW = vlmr_pkg::PAYLOAD_W + 1;
  localparam int unsigned XB   = (AW > MSGW) ? AW : MSGW;
  localparam int unsigned XW   = XB + 1;
  localparam int unsigned CNTW = $clog2(XW + 1);
  localparam int unsigned MW   = (XW > LW + 1) ? XW : LW + 1;
  localparam int unsigned FW   = (LW > MSGW) ? LW : MSGW;
  localparam int unsigned HCW  = (LW > vlmr_pkg::HDR_KEEP_W) ? LW : vlmr_pkg::HDR_KEEP_W;
  localparam int unsigned IW   = vlmr_pkg::HDR_IDX_W;

  // item registers
  logic [vlmr_pkg::KIND_W-1:0]    kind_q;
  logic [vlmr_pkg::PAYLOAD_W-1:0] payload_q;
  logic [vlmr_pkg::OFFSET_W-1:0]  offset_q;
  logic [vlmr_pkg::BYTE_W-1:0]    value_q;
  vlmr_pkg::kind_e                kind;

  always_ff @(posedge clk_i) begin
    if (cmd_i.item_load) begin
      payload_q <= s_tdata_i[12:0];
      offset_q  <= s_tdata_i[24:13];
      value_q   <= s_tdata_i[32:25];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      kind_q <= '0;
    end else if (cmd_i.item_load) begin
      kind_q <= s_tuser_i;
    end
  end

  assign kind = vlmr_pkg::kind_e'(kind_q);

  // ring size, pointers
  logic [vlmr_pkg::QLEN_W-1:0] qlen_q;
  logic [AW-1:0]               rp_q, wp_q;
  logic [LW-1:0]               len, rp_l, wp_l, av, free_b;
  logic                        rp_ok, wp_ok, ptrs_ok, empty;
  logic [MSGW-1:0]             msg;
  logic [LW-1:0]               r_q;

  always_comb begin
    if (CW'(qlen_q) > CW'(QUEUE_BYTES)) begin
      len = LW'(QUEUE_BYTES);
    end else if (qlen_q == '0) begin
      len = LW'(1);
    end else begin
      len = LW'(qlen_q);
    end
  end

  assign rp_l    = LW'(rp_q);
  assign wp_l    = LW'(wp_q);
  assign rp_ok   = rp_l < len;
  assign wp_ok   = wp_l < len;
  assign ptrs_ok = rp_ok && wp_ok;
  assign empty   = rp_q == wp_q;
  assign msg     = MSGW'(payload_q) + MSGW'(HEADER_BYTES);

  always_comb begin
    if (!ptrs_ok || empty) begin
      av = '0;
    end else if (wp_l > rp_l) begin
      av = wp_l - rp_l;
    end else begin
      av = len + wp_l - rp_l;
    end
  end

  assign free_b = len - LW'(1) - av;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      qlen_q <= vlmr_pkg::QLEN_RESET;
      rp_q   <= '0;
      wp_q   <= '0;
    end else if (cfg_we_i) begin
      qlen_q <= cfg_data_i;
      rp_q   <= '0;
      wp_q   <= '0;
    end else begin
      if (cmd_i.wp_load) begin
        wp_q <= AW'(r_q);
      end
      if (cmd_i.rp_load) begin
        rp_q <= AW'(r_q);
      end
    end
  end

  // modulo unit: one compare-subtract when the sum is below twice the ring
  // size, otherwise one remainder bit per cycle
  logic [XW-1:0]   x_q, x_in, base_x, opnd_x;
  logic [CNTW-1:0] cnt_q;
  logic            first_q;
  logic [LW:0]     r_shift, r_sub;
  logic [LW-1:0]   r_step;
  logic [MW-1:0]   x_m, len_m, len2_m, x_minus;

  always_comb begin
    case (kind)
      vlmr_pkg::KIND_PUT_BYTE, vlmr_pkg::KIND_ADD_COMPLETE: base_x = XW'(wp_q);
      default:                                              base_x = XW'(rp_q);
    endcase
    case (kind)
      vlmr_pkg::KIND_PUT_BYTE, vlmr_pkg::KIND_GET_BYTE: opnd_x = XW'(offset_q);
      default:                                          opnd_x = XW'(msg);
    endcase
  end

  assign x_in    = base_x + opnd_x;
  assign r_shift = {r_q, x_q[XW-1]};
  assign r_sub   = r_shift - {1'b0, len};
  assign r_step  = (r_shift >= {1'b0, len}) ? r_sub[LW-1:0] : r_shift[LW-1:0];
  assign x_m     = MW'(x_q);
  assign len_m   = MW'(len);
  assign len2_m  = len_m << 1;
  assign x_minus = x_m - len_m;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      first_q <= 1'b0;
    end else if (cmd_i.mod_start) begin
      cnt_q   <= '0;
      first_q <= 1'b1;
    end else if (first_q) begin
      first_q <= 1'b0;
      if (!(x_m < len2_m)) begin
        cnt_q <= CNTW'(XW);
      end
    end else if (cnt_q != '0) begin
      cnt_q <= cnt_q - CNTW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.mod_start) begin
      x_q <= x_in;
    end else if (first_q) begin
      if (x_m < len_m) begin
        r_q <= LW'(x_q);
      end else if (x_m < len2_m) begin
        r_q <= LW'(x_minus);
      end else begin
        r_q <= '0;
      end
    end else if (cnt_q != '0) begin
      r_q <= r_step;
      x_q <= x_q << 1;
    end
  end

  // header walk: issue one read a cycle, capture each byte from the registered read data
  logic [IW-1:0]                   idx_q, pend_idx_q;
  logic                            pend_q, sticky_q;
  logic [vlmr_pkg::HDR_KEEP_W-1:0] lo_q;
  logic [LW:0]                     h_sum, h_wrap;
  logic [AW-1:0]                   h_addr;
  logic [vlmr_pkg::BYTE_W-1:0]     rdata;

  assign h_sum  = {1'b0, rp_l} + (LW + 1)'(idx_q);
  assign h_wrap = (h_sum >= {1'b0, len}) ? h_sum - {1'b0, len} : h_sum;
  assign h_addr = AW'(h_wrap);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      idx_q  <= '0;
      pend_q <= 1'b0;
    end else if (cmd_i.hdr_start) begin
      idx_q  <= '0;
      pend_q <= 1'b0;
    end else if (cmd_i.hdr_rd) begin
      idx_q  <= idx_q + IW'(1);
      pend_q <= 1'b1;
    end else begin
      pend_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.hdr_rd) begin
      pend_idx_q <= idx_q;
    end
    if (cmd_i.hdr_start) begin
      lo_q     <= '0;
      sticky_q <= 1'b0;
    end else if (pend_q) begin
      if (pend_idx_q == IW'(0)) begin
        lo_q[7:0] <= rdata;
      end else if (pend_idx_q == IW'(1)) begin
        lo_q[15:8] <= rdata;
      end else begin
        sticky_q <= sticky_q | (|rdata);
      end
    end
  end

  vlmr_ram #(
    .WIDTH(vlmr_pkg::BYTE_W),
    .DEPTH(QUEUE_BYTES)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (cmd_i.ram_we),
    .waddr_i(AW'(r_q)),
    .wdata_i(value_q),
    .re_i   (cmd_i.ram_re || cmd_i.hdr_rd),
    .raddr_i(cmd_i.hdr_rd ? h_addr : AW'(r_q)),
    .rdata_o(rdata)
  );

  // result
  logic                          len_small, hdr_big, gc_ok;
  logic                          res_ok, res_err;
  logic [vlmr_pkg::RES_W-1:0]    res_size;
  logic [vlmr_pkg::BYTE_W-1:0]   res_data;
  logic                          m_valid_q;
  logic [vlmr_pkg::M_TDATA_W-1:0] m_data_q;

  assign len_small = len <= LW'(HEADER_BYTES);
  assign hdr_big   = sticky_q || (HCW'(lo_q) >= HCW'(len - LW'(HEADER_BYTES)));
  assign gc_ok     = rp_ok && (FW'(msg) < FW'(len));

  always_comb begin
    res_ok   = 1'b0;
    res_err  = 1'b0;
    res_size = '0;
    res_data = '0;
    case (kind)
      vlmr_pkg::KIND_ADD_BEGIN:    res_ok = ptrs_ok && (FW'(msg) <= FW'(free_b));
      vlmr_pkg::KIND_PUT_BYTE:     res_ok = 1'b1;
      vlmr_pkg::KIND_ADD_COMPLETE: res_ok = wp_ok;
      vlmr_pkg::KIND_GET_BEGIN: begin
        if (!ptrs_ok) begin
          res_err = 1'b1;
        end else if (!empty) begin
          if (len_small || hdr_big) begin
            res_err = 1'b1;
          end else begin
            res_ok   = 1'b1;
            res_size = vlmr_pkg::RES_W'(lo_q + vlmr_pkg::HDR_KEEP_W'(HEADER_BYTES));
          end
        end
      end
      vlmr_pkg::KIND_GET_BYTE: begin
        res_ok   = 1'b1;
        res_data = rdata;
      end
      vlmr_pkg::KIND_GET_COMPLETE: res_ok = gc_ok;
      default: begin
        res_ok = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m_valid_q <= 1'b0;
    end else if (cmd_i.out_load) begin
      m_valid_q <= 1'b1;
    end else if (m_tready_i) begin
      m_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      m_data_q <= {2'b00,
                   vlmr_pkg::RES_W'(free_b),
                   vlmr_pkg::RES_W'(av),
                   res_data, res_size, res_err, res_ok};
    end
  end

  assign m_tvalid_o = m_valid_q;
  assign m_tdata_o  = m_data_q;

  always_comb begin
    sts_o           = '0;
    sts_o.kind      = kind;
    sts_o.wp_ok     = wp_ok;
    sts_o.ptrs_ok   = ptrs_ok;
    sts_o.empty     = empty;
    sts_o.len_small = len_small;
    sts_o.gc_ok     = gc_ok;
    sts_o.mod_done  = !first_q && (cnt_q == '0);
    sts_o.hdr_last  = idx_q == IW'(vlmr_pkg::HDR_LEN_BYTES - 1);
    sts_o.out_free  = !m_valid_q || m_tready_i;
  end

endmodule

FILE: rtl/variable_length_message_ring.sv
// Top level of the variable-length message ring: controller plus datapath.
//
//  channel  direction  handshake                     content
//  s_axis   in         s_axis_tvalid_i/tready_o      one operation beat
//  m_axis   out        m_axis_tvalid_o/tready_i      one result beat per operation
//  cfg      in         cfg_valid_i/cfg_ready_o       queue_length write
//
// One operation at a time. add_begin and the early-rejected cases go from
// accept straight to the result; put_byte, get_byte and the pointer advances
// pass through the modulo unit first, which works bit-serially through the
// sum of pointer and offset or message length when that sum reaches twice the
// ring size (15 bits wide at the default size); get_begin first makes one
// store read per header length byte. Reset clears both pointers and sets
// queue_length to 4096; the store is not cleared. A stalled result holds in
// the output register; the next beat is taken meanwhile, its result waiting for the slot.
module variable_length_message_ring #(
  parameter int unsigned QUEUE_BYTES  = 4096,
  parameter int unsigned HEADER_BYTES = 16
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  // payload_length[12:0], byte_offset[24:13], byte_value[32:25], zero above
  input  logic [vlmr_pkg::S_TDATA_W-1:0] s_axis_tdata_i,
  // kind[2:0]
  input  logic [vlmr_pkg::S_TUSER_W-1:0] s_axis_tuser_i,
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  // ok[0], error[1], message_size[13:2], data_byte[21:14],
  // avail_bytes[33:22], free_bytes[45:34], zero above
  output logic [vlmr_pkg::M_TDATA_W-1:0] m_axis_tdata_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [vlmr_pkg::QLEN_W-1:0]    cfg_data_i
);

  vlmr_pkg::cmd_t cmd;
  vlmr_pkg::sts_t sts;
  logic           cfg_we;

  assign cfg_we = cfg_valid_i && cfg_ready_o;

  vlmr_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_valid_i  (s_axis_tvalid_i),
    .cfg_valid_i(cfg_valid_i),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .s_ready_o  (s_axis_tready_o),
    .cfg_ready_o(cfg_ready_o)
  );

  vlmr_dp #(
    .QUEUE_BYTES (QUEUE_BYTES),
    .HEADER_BYTES(HEADER_BYTES)
  ) u_dp (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .cmd_i     (cmd),
    .sts_o     (sts),
    .cfg_we_i  (cfg_we),
    .cfg_data_i(cfg_data_i),
    .s_tdata_i (s_axis_tdata_i),
    .s_tuser_i (s_axis_tuser_i),
    .m_tready_i(m_axis_tready_i),
    .m_tvalid_o(m_axis_tvalid_o),
    .m_tdata_o (m_axis_tdata_o)
  );

endmodule

FILE: rtl/vlmr_checker.sv
// Port-level checks for the message ring, bound to the top level.
module vlmr_checker (
  input logic                           clk_i,
  input logic                           rst_ni,
  input logic                           s_axis_tvalid_i,
  input logic                           s_axis_tready_o,
  input logic                           m_axis_tvalid_o,
  input logic                           m_axis_tready_i,
  input logic [vlmr_pkg::M_TDATA_W-1:0] m_axis_tdata_o,
  input logic                           cfg_valid_i,
  input logic                           cfg_ready_o
);

  // a stalled result beat stays up
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && !m_axis_tready_i) |=> m_axis_tvalid_o)
    else $error("result beat dropped while stalled");

  // a result never appears in the cycle right after an operation is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid_i && s_axis_tready_o) |=> !$rose(m_axis_tvalid_o))
    else $error("result appeared too early");

  // a configuration write and an operation beat never share a cycle
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (cfg_valid_i && cfg_ready_o) |-> !s_axis_tready_o)
    else $error("operation taken during configuration write");

  // success and error are exclusive
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> !(m_axis_tdata_o[0] && m_axis_tdata_o[1]))
    else $error("result flags both ok and error");

endmodule

bind variable_length_message_ring vlmr_checker u_vlmr_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .s_axis_tvalid_i(s_axis_tvalid_i),
  .s_axis_tready_o(s_axis_tready_o),
  .m_axis_tvalid_o(m_axis_tvalid_o),
  .m_axis_tready_i(m_axis_tready_i),
  .m_axis_tdata_o (m_axis_tdata_o),
  .cfg_valid_i    (cfg_valid_i),
  .cfg_ready_o    (cfg_ready_o)
);
